// ----- rtl/btcc_pkg.sv -----
`default_nettype none
package btcc_pkg;

  localparam int unsigned FullSoc     = 995;
  localparam int unsigned FullTailMa  = 50;
  localparam int unsigned DarkMa      = 20;
  localparam int unsigned EmptySoc    = 10;
  localparam int unsigned DarkLimitMs = 300000;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_FULL   = 3'd1,
    CAUSE_DARK   = 3'd2,
    CAUSE_CUTOFF = 3'd3,
    CAUSE_CRIT   = 3'd4,
    CAUSE_CYCLE  = 3'd5,
    CAUSE_MANUAL = 3'd6
  } cause_t;

  typedef enum logic [1:0] {
    OVR_NONE  = 2'd0,
    OVR_EMPTY = 2'd1,
    OVR_FULL  = 2'd2
  } ovr_t;

  localparam logic [2:0] MODE_USB    = 3'd0;
  localparam logic [2:0] MODE_PV     = 3'd1;
  localparam logic [2:0] MODE_DIS    = 3'd2;
  localparam logic [2:0] MODE_VERIFY = 3'd3;
  localparam logic [2:0] MODE_AUTO   = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_CUTOFF = 2'd1;
  localparam logic [1:0] REG_CRIT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_OUT
  } bst_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    logic [15:0] interval_ms;
    logic [15:0] battery_mv;
    logic [14:0] charge_ma;
    logic [15:0] load_mv;
    logic [14:0] load_ma;
    logic [9:0]  soc_tenths;
    logic        full;
    logic        empty;
    logic        dark;
    logic        crit;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/battery_test_cycle_controller_core.sv -----
`default_nettype none
// Channel   Direction  Handshake             Payload
// in_       input      in_valid/in_ready     kind, now_ms, interval_ms, readings, soc
// out_      output     out_valid/out_ready   status, counters, energies, soc_change
// cfg_      config     APB psel/penable      test_mode, cutoff, critical soc
// The back sequencer takes each item through five steps: take it from the queue, two
// multiply stages, one accumulate step, then the result register.
// With an idle back, out_valid rises once the item has passed the queue, MUL1, MUL2
// and ACC; the back takes no new item until the receiver has taken the last result.
// A two-entry queue lets the front take items while the back is busy.
// Reset is synchronous, active low; it clears the run state and the queue.
// A stalled result holds the back; the front stalls once the queue is full.
module battery_test_cycle_controller_core #(
  parameter int unsigned QueueDepth = btcc_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_kind,
  input  wire logic [31:0]   in_now_ms,
  input  wire logic [15:0]   in_interval_ms,
  input  wire logic [15:0]   in_battery_mv,
  input  wire logic [14:0]   in_charge_ma,
  input  wire logic [15:0]   in_load_mv,
  input  wire logic [14:0]   in_load_ma,
  input  wire logic [9:0]    in_soc_tenths,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_accepted,
  output logic               out_running,
  output logic               out_finished,
  output logic [2:0]         out_end_cause,
  output logic [1:0]         out_soc_override,
  output logic [22:0]        out_run_secs,
  output logic [31:0]        out_sample_total,
  output logic [63:0]        out_energy_in_nj,
  output logic [63:0]        out_energy_out_nj,
  output logic signed [10:0] out_soc_change,
  output logic [1:0]         out_cycle_phase,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [2:0]  mode;
  logic [15:0] cut;
  logic [9:0]  crit;
  logic        qv, qr;
  btcc_pkg::item_t qi;

  btcc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .test_mode(mode), .cutoff_mv(cut), .crit_soc(crit)
  );

  btcc_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_now_ms, .in_interval_ms,
    .in_battery_mv, .in_charge_ma, .in_load_mv, .in_load_ma, .in_soc_tenths,
    .cutoff_mv(cut), .crit_soc(crit), .q_valid(qv), .q_ready(qr), .q_item(qi)
  );

  btcc_back u_back (
    .clk, .rst_n, .q_valid(qv), .q_ready(qr), .q_item(qi), .test_mode(mode),
    .out_valid, .out_ready, .out_accepted, .out_running, .out_finished,
    .out_end_cause, .out_soc_override, .out_run_secs, .out_sample_total,
    .out_energy_in_nj, .out_energy_out_nj, .out_soc_change, .out_cycle_phase
  );
endmodule
`default_nettype wire

// ----- rtl/btcc_front.sv -----
`default_nettype none
module btcc_front #(
  parameter int unsigned Depth = btcc_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_kind,
  input  wire logic [31:0]     in_now_ms,
  input  wire logic [15:0]     in_interval_ms,
  input  wire logic [15:0]     in_battery_mv,
  input  wire logic [14:0]     in_charge_ma,
  input  wire logic [15:0]     in_load_mv,
  input  wire logic [14:0]     in_load_ma,
  input  wire logic [9:0]      in_soc_tenths,
  input  wire logic [15:0]     cutoff_mv,
  input  wire logic [9:0]      crit_soc,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output btcc_pkg::item_t      q_item
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  btcc_pkg::item_t mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  btcc_pkg::item_t cls;
  logic push, pop;

  always_comb begin
    cls.kind        = btcc_pkg::kind_t'(in_kind);
    cls.now_ms      = in_now_ms;
    cls.interval_ms = in_interval_ms;
    cls.battery_mv  = in_battery_mv;
    cls.charge_ma   = in_charge_ma;
    cls.load_mv     = in_load_mv;
    cls.load_ma     = in_load_ma;
    cls.soc_tenths  = in_soc_tenths;
    cls.full  = (in_soc_tenths >= 10'(btcc_pkg::FullSoc)) &&
                (in_charge_ma < 15'(btcc_pkg::FullTailMa));
    cls.empty = (in_load_mv <= cutoff_mv) || (in_soc_tenths <= 10'(btcc_pkg::EmptySoc));
    cls.dark  = in_charge_ma < 15'(btcc_pkg::DarkMa);
    cls.crit  = in_soc_tenths <= crit_soc;
  end

  assign in_ready = cnt_r != (AW+1)'(Depth);
  assign q_valid  = cnt_r != '0;
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule
`default_nettype wire

// ----- rtl/btcc_back.sv -----
`default_nettype none
module btcc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire btcc_pkg::item_t q_item,
  input  wire logic [2:0]      test_mode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_accepted,
  output logic                 out_running,
  output logic                 out_finished,
  output logic [2:0]           out_end_cause,
  output logic [1:0]           out_soc_override,
  output logic [22:0]          out_run_secs,
  output logic [31:0]          out_sample_total,
  output logic [63:0]          out_energy_in_nj,
  output logic [63:0]          out_energy_out_nj,
  output logic signed [10:0]   out_soc_change,
  output logic [1:0]           out_cycle_phase
);
  btcc_pkg::bst_t st_r, st_nxt;
  btcc_pkg::item_t it_r;

  logic        active_r, active_nxt;
  logic [31:0] start_r, start_nxt;
  logic [9:0]  ssoc_r, ssoc_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [63:0] ein_r, ein_nxt, eout_r, eout_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        dk_r, dk_nxt;
  logic [31:0] dks_r, dks_nxt;
  logic [30:0] pin_r, pout_r;
  logic [46:0] ein_d_r, eout_d_r;
  logic [31:0] diff_r;
  logic [31:0] q_r;

  logic        acc_r, acc_nxt, fin_r, fin_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic [1:0]  ovr_r, ovr_nxt;
  logic [22:0] el_r, el_nxt;
  logic [10:0] chg_r, chg_nxt;

  logic [64:0] sum_in, sum_out;
  logic [31:0] dk_el;
  logic [63:0] q_mul;
  logic [31:0] q_est, r_est;

  assign q_ready = (st_r == btcc_pkg::ST_IDLE);
  assign out_valid = (st_r == btcc_pkg::ST_OUT);
  assign out_accepted = acc_r;
  assign out_running = active_r;
  assign out_finished = fin_r;
  assign out_end_cause = cause_r;
  assign out_soc_override = ovr_r;
  assign out_run_secs = el_r;
  assign out_sample_total = cnt_r;
  assign out_energy_in_nj = ein_r;
  assign out_energy_out_nj = eout_r;
  assign out_soc_change = chg_r;
  assign out_cycle_phase = ph_r;

  assign sum_in  = {1'b0, ein_r} + {17'd0, ein_d_r};
  assign sum_out = {1'b0, eout_r} + {17'd0, eout_d_r};
  assign dk_el = it_r.now_ms - dks_r;
  // Divide by 1000 as a reciprocal multiply with one correction step.
  assign q_mul = {32'd0, diff_r} * 64'd4294967;
  assign q_est = q_mul[63:32];
  assign r_est = diff_r - 32'(q_r * 32'd1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= btcc_pkg::ST_IDLE;
      active_r <= 1'b0;
      start_r <= '0;
      ssoc_r <= '0;
      cnt_r <= '0;
      ein_r <= '0;
      eout_r <= '0;
      ph_r <= '0;
      dk_r <= 1'b0;
      dks_r <= '0;
      acc_r <= 1'b0;
      fin_r <= 1'b0;
      cause_r <= '0;
      ovr_r <= '0;
      el_r <= '0;
      chg_r <= '0;
    end else begin
      st_r <= st_nxt;
      active_r <= active_nxt;
      start_r <= start_nxt;
      ssoc_r <= ssoc_nxt;
      cnt_r <= cnt_nxt;
      ein_r <= ein_nxt;
      eout_r <= eout_nxt;
      ph_r <= ph_nxt;
      dk_r <= dk_nxt;
      dks_r <= dks_nxt;
      acc_r <= acc_nxt;
      fin_r <= fin_nxt;
      cause_r <= cause_nxt;
      ovr_r <= ovr_nxt;
      el_r <= el_nxt;
      chg_r <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) it_r <= q_item;
    if (st_r == btcc_pkg::ST_MUL1) begin
      pin_r  <= 31'(it_r.battery_mv * it_r.charge_ma);
      pout_r <= 31'(it_r.load_mv * it_r.load_ma);
      diff_r <= it_r.now_ms - start_r;
    end
    if (st_r == btcc_pkg::ST_MUL2) begin
      ein_d_r  <= 47'(pin_r * it_r.interval_ms);
      eout_d_r <= 47'(pout_r * it_r.interval_ms);
      q_r      <= q_est;
    end
  end

  always_comb begin
    st_nxt = st_r;
    active_nxt = active_r;
    start_nxt = start_r;
    ssoc_nxt = ssoc_r;
    cnt_nxt = cnt_r;
    ein_nxt = ein_r;
    eout_nxt = eout_r;
    ph_nxt = ph_r;
    dk_nxt = dk_r;
    dks_nxt = dks_r;
    acc_nxt = acc_r;
    fin_nxt = fin_r;
    cause_nxt = cause_r;
    ovr_nxt = ovr_r;
    el_nxt = el_r;
    chg_nxt = chg_r;
    case (st_r)
      btcc_pkg::ST_IDLE: begin
        if (q_valid) st_nxt = btcc_pkg::ST_MUL1;
      end
      btcc_pkg::ST_MUL1: st_nxt = btcc_pkg::ST_MUL2;
      btcc_pkg::ST_MUL2: st_nxt = btcc_pkg::ST_ACC;
      btcc_pkg::ST_ACC: begin
        st_nxt = btcc_pkg::ST_OUT;
        acc_nxt = 1'b0;
        fin_nxt = 1'b0;
        cause_nxt = btcc_pkg::CAUSE_NONE;
        ovr_nxt = btcc_pkg::OVR_NONE;
        el_nxt = '0;
        chg_nxt = '0;
        if (active_r && it_r.kind != btcc_pkg::KIND_NONE) begin
          el_nxt = 23'((r_est >= 32'd1000) ? q_r + 32'd1 : q_r);
          chg_nxt = 11'({1'b0, it_r.soc_tenths} - {1'b0, ssoc_r});
        end
        case (it_r.kind)
          btcc_pkg::KIND_START: begin
            if (!active_r) begin
              acc_nxt = 1'b1;
              active_nxt = 1'b1;
              start_nxt = it_r.now_ms;
              ssoc_nxt = it_r.soc_tenths;
              cnt_nxt = '0;
              ein_nxt = '0;
              eout_nxt = '0;
              ph_nxt = '0;
              dk_nxt = 1'b0;
              dks_nxt = '0;
            end
          end
          btcc_pkg::KIND_STOP: begin
            if (active_r) begin
              active_nxt = 1'b0;
              fin_nxt = 1'b1;
              cause_nxt = btcc_pkg::CAUSE_MANUAL;
            end
          end
          btcc_pkg::KIND_SAMPLE: begin
            if (active_r) begin
              if (cnt_r != '1) cnt_nxt = cnt_r + 32'd1;
              ein_nxt  = sum_in[64] ? '1 : sum_in[63:0];
              eout_nxt = sum_out[64] ? '1 : sum_out[63:0];
              case (test_mode)
                btcc_pkg::MODE_USB: begin
                  if (it_r.full) begin
                    cause_nxt = btcc_pkg::CAUSE_FULL;
                    ovr_nxt = btcc_pkg::OVR_FULL;
                  end
                end
                btcc_pkg::MODE_PV: begin
                  if (it_r.full) begin
                    cause_nxt = btcc_pkg::CAUSE_FULL;
                    ovr_nxt = btcc_pkg::OVR_FULL;
                  end else if (it_r.dark) begin
                    if (!dk_r) begin
                      dk_nxt = 1'b1;
                      dks_nxt = it_r.now_ms;
                    end else if (dk_el > 32'(btcc_pkg::DarkLimitMs)) begin
                      cause_nxt = btcc_pkg::CAUSE_DARK;
                      dk_nxt = 1'b0;
                    end
                  end else begin
                    dk_nxt = 1'b0;
                  end
                end
                btcc_pkg::MODE_DIS: begin
                  if (it_r.empty) begin
                    cause_nxt = btcc_pkg::CAUSE_CUTOFF;
                    ovr_nxt = btcc_pkg::OVR_EMPTY;
                  end
                end
                btcc_pkg::MODE_VERIFY: begin
                  case (ph_r)
                    2'd0: if (it_r.empty) begin
                      ovr_nxt = btcc_pkg::OVR_EMPTY;
                      ph_nxt = 2'd1;
                    end
                    2'd1: if (it_r.full) begin
                      ovr_nxt = btcc_pkg::OVR_FULL;
                      ph_nxt = 2'd2;
                    end
                    2'd2: if (it_r.empty) begin
                      ph_nxt = 2'd3;
                      cause_nxt = btcc_pkg::CAUSE_CYCLE;
                    end
                    default: ;
                  endcase
                end
                btcc_pkg::MODE_AUTO: begin
                  if (it_r.crit) cause_nxt = btcc_pkg::CAUSE_CRIT;
                end
                default: ;
              endcase
              if (cause_nxt != btcc_pkg::CAUSE_NONE) begin
                active_nxt = 1'b0;
                fin_nxt = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      btcc_pkg::ST_OUT: begin
        if (out_ready) st_nxt = btcc_pkg::ST_IDLE;
      end
      default: st_nxt = btcc_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/btcc_regs.sv -----
`default_nettype none
module btcc_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [2:0]       test_mode,
  output logic [15:0]      cutoff_mv,
  output logic [9:0]       crit_soc
);
  logic [2:0]  mode_r;
  logic [15:0] cut_r;
  logic [9:0]  crit_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign test_mode = mode_r;
  assign cutoff_mv = cut_r;
  assign crit_soc = crit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'd0;
      cut_r  <= 16'd3000;
      crit_r <= 10'd100;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        btcc_pkg::REG_MODE:   mode_r <= pwdata[2:0];
        btcc_pkg::REG_CUTOFF: cut_r  <= pwdata[15:0];
        btcc_pkg::REG_CRIT:   crit_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      btcc_pkg::REG_MODE:   prdata = {29'd0, mode_r};
      btcc_pkg::REG_CUTOFF: prdata = {16'd0, cut_r};
      btcc_pkg::REG_CRIT:   prdata = {22'd0, crit_r};
      default:              prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/btcc_checker.sv -----
`default_nettype none
module btcc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_accepted,
  input wire logic       out_running,
  input wire logic       out_finished,
  input wire logic [2:0] out_end_cause
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_end_cause))
    else $error("result dropped while stalled");
  a_fin_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finished == (out_end_cause != btcc_pkg::CAUSE_NONE)))
    else $error("finished and end cause disagree");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_running)
    else $error("finished run still running");
  a_acc_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_running && !out_finished)
    else $error("accepted start not running");
endmodule

bind battery_test_cycle_controller_core btcc_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_accepted, .out_running,
  .out_finished, .out_end_cause
);
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

  typedef struct {
    btcc_pkg::kind_t kind;
    logic [31:0] now_ms;
    logic [15:0] dt_ms;
    logic [15:0] vbat;
    logic [14:0] ichg;
    logic [15:0] vload;
    logic [14:0] iload;
    logic [9:0]  soc;
  } stim_t;

  typedef struct {
    logic        accepted;
    logic        running;
    logic        finished;
    logic [2:0]  cause;
    logic [1:0]  ovr;
    logic [22:0] elapsed;
    logic [31:0] total;
    logic [63:0] e_in;
    logic [63:0] e_out;
    logic [10:0] dsoc;
    logic [1:0]  phase;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [31:0] in_now_ms = '0;
  logic [15:0] in_interval_ms = '0;
  logic [15:0] in_battery_mv = '0;
  logic [14:0] in_charge_ma = '0;
  logic [15:0] in_load_mv = '0;
  logic [14:0] in_load_ma = '0;
  logic [9:0] in_soc_tenths = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted, out_running, out_finished;
  logic [2:0] out_end_cause;
  logic [1:0] out_soc_override;
  logic [22:0] out_run_secs;
  logic [31:0] out_sample_total;
  logic [63:0] out_energy_in_nj, out_energy_out_nj;
  logic signed [10:0] out_soc_change;
  logic [1:0] out_cycle_phase;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  battery_test_cycle_controller_core DUT (.*);

  // Controller model state and registers.
  logic [2:0]  mode_r;
  logic [15:0] cutoff_r;
  logic [9:0]  crit_r;
  logic        run_on;
  logic [31:0] run_t0;
  logic [9:0]  soc0;
  logic [31:0] n_samples;
  logic [63:0] e_in_acc, e_out_acc;
  logic [1:0]  vphase;
  logic        dark_on;
  logic [31:0] dark_t0;

  status_t expected_status[$];
  int errors = 0;
  int burst_left = 0;
  int items_sent = 0;
  logic [31:0] clock_ms = '0;
  logic hold_go = 1'b0, hold_seen = 1'b0;
  int hold_left = 0;
  int stall_pct = 0;
  int rx_cyc = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic status_t controller_step(stim_t s);
    status_t r;
    logic full, empty;
    r = '{default: '0};
    full = (s.soc >= btcc_pkg::FullSoc) && (s.ichg < btcc_pkg::FullTailMa);
    empty = (s.vload <= cutoff_r) || (s.soc <= btcc_pkg::EmptySoc);
    if (s.kind == btcc_pkg::KIND_START) begin
      if (!run_on) begin
        r.accepted = 1'b1;
        run_on = 1'b1;
        run_t0 = s.now_ms;
        soc0 = s.soc;
        n_samples = '0;
        e_in_acc = '0;
        e_out_acc = '0;
        vphase = '0;
        dark_on = 1'b0;
        dark_t0 = '0;
      end else begin
        r.elapsed = 23'((s.now_ms - run_t0) / 1000);
        r.dsoc = 11'({1'b0, s.soc} - {1'b0, soc0});
      end
    end else if (s.kind == btcc_pkg::KIND_STOP) begin
      if (run_on) begin
        r.elapsed = 23'((s.now_ms - run_t0) / 1000);
        r.dsoc = 11'({1'b0, s.soc} - {1'b0, soc0});
        run_on = 1'b0;
        r.finished = 1'b1;
        r.cause = btcc_pkg::CAUSE_MANUAL;
      end
    end else if (s.kind == btcc_pkg::KIND_SAMPLE && run_on) begin
      r.elapsed = 23'((s.now_ms - run_t0) / 1000);
      r.dsoc = 11'({1'b0, s.soc} - {1'b0, soc0});
      if (n_samples != '1) n_samples = n_samples + 1;
      e_in_acc = sat_sum(e_in_acc, 64'(s.vbat) * 64'(s.ichg) * 64'(s.dt_ms));
      e_out_acc = sat_sum(e_out_acc, 64'(s.vload) * 64'(s.iload) * 64'(s.dt_ms));
      case (mode_r)
        btcc_pkg::MODE_USB: begin
          if (full) begin
            r.cause = btcc_pkg::CAUSE_FULL;
            r.ovr = btcc_pkg::OVR_FULL;
          end
        end
        btcc_pkg::MODE_PV: begin
          if (full) begin
            r.cause = btcc_pkg::CAUSE_FULL;
            r.ovr = btcc_pkg::OVR_FULL;
          end else if (s.ichg < btcc_pkg::DarkMa) begin
            if (!dark_on) begin
              dark_on = 1'b1;
              dark_t0 = s.now_ms;
            end else if ((s.now_ms - dark_t0) > btcc_pkg::DarkLimitMs) begin
              r.cause = btcc_pkg::CAUSE_DARK;
              dark_on = 1'b0;
            end
          end else begin
            dark_on = 1'b0;
          end
        end
        btcc_pkg::MODE_DIS: begin
          if (empty) begin
            r.cause = btcc_pkg::CAUSE_CUTOFF;
            r.ovr = btcc_pkg::OVR_EMPTY;
          end
        end
        btcc_pkg::MODE_VERIFY: begin
          // Discharge to empty, charge to full, then discharge to empty again.
          if (vphase == 2'd0) begin
            if (empty) begin
              r.ovr = btcc_pkg::OVR_EMPTY;
              vphase = 2'd1;
            end
          end else if (vphase == 2'd1) begin
            if (full) begin
              r.ovr = btcc_pkg::OVR_FULL;
              vphase = 2'd2;
            end
          end else if (vphase == 2'd2) begin
            if (empty) begin
              vphase = 2'd3;
              r.cause = btcc_pkg::CAUSE_CYCLE;
            end
          end
        end
        btcc_pkg::MODE_AUTO: begin
          if (s.soc <= crit_r) r.cause = btcc_pkg::CAUSE_CRIT;
        end
        default: begin
        end
      endcase
      if (r.cause != btcc_pkg::CAUSE_NONE) begin
        run_on = 1'b0;
        r.finished = 1'b1;
      end
    end
    r.running = run_on;
    r.total = n_samples;
    r.e_in = e_in_acc;
    r.e_out = e_out_acc;
    r.phase = vphase;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(out_end_cause), 64'(0));
      end else begin
        want = expected_status.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_accepted), 64'(want.accepted));
        if (out_running !== want.running)
          report_mismatch("running", 64'(out_running), 64'(want.running));
        if (out_finished !== want.finished)
          report_mismatch("finished", 64'(out_finished), 64'(want.finished));
        if (out_end_cause !== want.cause)
          report_mismatch("end_cause", 64'(out_end_cause), 64'(want.cause));
        if (out_soc_override !== want.ovr)
          report_mismatch("soc_override", 64'(out_soc_override), 64'(want.ovr));
        if (out_run_secs !== want.elapsed)
          report_mismatch("run_secs", 64'(out_run_secs), 64'(want.elapsed));
        if (out_sample_total !== want.total)
          report_mismatch("sample_total", 64'(out_sample_total), 64'(want.total));
        if (out_energy_in_nj !== want.e_in)
          report_mismatch("energy_in_nj", out_energy_in_nj, want.e_in);
        if (out_energy_out_nj !== want.e_out)
          report_mismatch("energy_out_nj", out_energy_out_nj, want.e_out);
        if (out_soc_change !== want.dsoc)
          report_mismatch("soc_change", 64'(out_soc_change), 64'(want.dsoc));
        if (out_cycle_phase !== want.phase)
          report_mismatch("cycle_phase", 64'(out_cycle_phase), 64'(want.phase));
      end
    end
  end

  // Receiver: stretches of full readiness alternate with random stalls, and a
  // requested hold-off keeps ready low for a long stretch.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 10 :
                                       ($urandom_range(0, 1) ? 50 : 80);
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_cyc % 512 < 128) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(stim_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_now_ms <= s.now_ms;
    in_interval_ms <= s.dt_ms;
    in_battery_mv <= s.vbat;
    in_charge_ma <= s.ichg;
    in_load_mv <= s.vload;
    in_load_ma <= s.iload;
    in_soc_tenths <= s.soc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(controller_step(s));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      btcc_pkg::REG_MODE: mode_r = value[2:0];
      btcc_pkg::REG_CUTOFF: cutoff_r = value[15:0];
      btcc_pkg::REG_CRIT: crit_r = value[9:0];
      default: ;
    endcase
  endtask

  function automatic stim_t make_item(btcc_pkg::kind_t k, logic [31:0] now,
                                      logic [15:0] dt, logic [14:0] ichg,
                                      logic [15:0] vload, logic [9:0] soc);
    stim_t s;
    s.kind = k;
    s.now_ms = now;
    s.dt_ms = dt;
    s.vbat = 16'($urandom);
    s.ichg = ichg;
    s.vload = vload;
    s.iload = 15'($urandom);
    s.soc = soc;
    return s;
  endfunction

  function automatic stim_t rand_sample();
    stim_t s;
    logic [15:0] dt;
    dt = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(60000, 65535)) : 16'($urandom);
    clock_ms = clock_ms + dt;
    s = make_item(btcc_pkg::KIND_SAMPLE, clock_ms, dt, 15'($urandom), 16'($urandom),
                  10'($urandom_range(0, 1000)));
    case ($urandom_range(0, 3))
      0: s.soc = 10'($urandom_range(990, 1000));
      1: s.soc = 10'($urandom_range(0, 12));
      2: s.soc = (crit_r > 2) ? crit_r + 10'($urandom_range(0, 4)) - 10'd2 : crit_r;
      default: ;
    endcase
    if (s.soc > 10'd1000) s.soc = 10'd1000;
    if ($urandom_range(0, 1)) s.ichg = 15'($urandom_range(0, 60));
    if ($urandom_range(0, 2) == 0)
      s.vload = (cutoff_r < 16'hFFFF) ? cutoff_r + 16'($urandom_range(0, 1)) : cutoff_r;
    return s;
  endfunction

  task automatic test_idle_and_refusal();
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd5, 16'd5, 15'd1, 16'd1, 10'd500));
    send_item(make_item(btcc_pkg::KIND_STOP, 32'd6, 16'd0, 15'd1, 16'd1, 10'd500));
    send_item(make_item(btcc_pkg::KIND_NONE, 32'd7, 16'd0, 15'd1, 16'd1, 10'd500));
    send_item(make_item(btcc_pkg::KIND_START, 32'hFFFF_FC00, 16'd0, 15'd0, 16'd0,
                        10'd1000));
    send_item(make_item(btcc_pkg::KIND_START, 32'h0000_2000, 16'd0, 15'd0, 16'd0,
                        10'd0));
    send_item('{btcc_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF,
                16'hFFFF, 15'h7FFF, 10'd1000});
    send_item('{btcc_pkg::KIND_SAMPLE, 32'h0001_0000, 16'd0, 16'd0, 15'd0, 16'hFFFF,
                15'd0, 10'd0});
    send_item(make_item(btcc_pkg::KIND_STOP, 32'h0002_0000, 16'd0, 15'd0, 16'd0, 10'd0));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'h0002_0001, 16'd9, 15'd9, 16'd9,
                        10'd9));
    drain_results();
  endtask

  task automatic test_stop_rules();
    write_reg(btcc_pkg::REG_MODE, 32'(btcc_pkg::MODE_USB));
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd800));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd100, 16'd100, 15'd49, 16'hFFFF,
                        10'd995));
    drain_results();
    write_reg(btcc_pkg::REG_MODE, 32'(btcc_pkg::MODE_PV));
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd1000, 16'd1000, 15'd0, 16'hFFFF,
                        10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd301000, 16'd65535, 15'd19, 16'hFFFF,
                        10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd301001, 16'd1, 15'd0, 16'hFFFF,
                        10'd500));
    drain_results();
    write_reg(btcc_pkg::REG_MODE, 32'(btcc_pkg::MODE_DIS));
    write_reg(btcc_pkg::REG_CUTOFF, 32'd3300);
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd10, 16'd10, 15'd5, 16'd3301, 10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd20, 16'd10, 15'd5, 16'd3300, 10'd500));
    drain_results();
    write_reg(btcc_pkg::REG_MODE, 32'(btcc_pkg::MODE_VERIFY));
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd10, 16'd10, 15'd5, 16'hFFFF, 10'd10));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd20, 16'd10, 15'd5, 16'hFFFF,
                        10'd1000));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd30, 16'd10, 15'd5, 16'd100, 10'd500));
    drain_results();
    write_reg(btcc_pkg::REG_MODE, 32'(btcc_pkg::MODE_AUTO));
    write_reg(btcc_pkg::REG_CRIT, 32'd1000);
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd500));
    send_item(make_item(btcc_pkg::KIND_SAMPLE, 32'd10, 16'd10, 15'd5, 16'hFFFF,
                        10'd1000));
    drain_results();
  endtask

  task automatic run_sequence();
    int n;
    stim_t s;
    n = $urandom_range(2, 25);
    clock_ms = ($urandom_range(0, 4) == 0) ? 32'hFFFF_0000 + 32'($urandom) % 32'hFFFF
                                           : 32'($urandom);
    send_item(make_item(btcc_pkg::KIND_START, clock_ms, 16'($urandom), 15'($urandom),
                        16'($urandom), 10'($urandom_range(0, 1000))));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(make_item(btcc_pkg::KIND_START, clock_ms, 16'($urandom),
                               15'($urandom), 16'($urandom),
                               10'($urandom_range(0, 1000))));
        1: send_item(make_item(btcc_pkg::KIND_NONE, 32'($urandom), 16'($urandom),
                               15'($urandom), 16'($urandom),
                               10'($urandom_range(0, 1000))));
        default: send_item(rand_sample());
      endcase
    end
    if ($urandom_range(0, 9) < 7) begin
      s = rand_sample();
      s.kind = btcc_pkg::KIND_STOP;
      send_item(s);
    end
  endtask

  task automatic test_random_runs();
    logic [2:0] m;
    while (items_sent < 640) begin
      drain_results();
      m = ($urandom_range(0, 7) == 0) ?
          3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)) :
          3'($urandom_range(btcc_pkg::MODE_USB, btcc_pkg::MODE_AUTO));
      write_reg(btcc_pkg::REG_MODE, 32'(m));
      case ($urandom_range(0, 3))
        0: write_reg(btcc_pkg::REG_CUTOFF, 32'd0);
        1: write_reg(btcc_pkg::REG_CUTOFF, 32'hFFFF);
        default: write_reg(btcc_pkg::REG_CUTOFF, $urandom_range(2500, 4200));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(btcc_pkg::REG_CRIT, 32'd0);
        1: write_reg(btcc_pkg::REG_CRIT, 32'd1000);
        default: write_reg(btcc_pkg::REG_CRIT, $urandom_range(0, 1000));
      endcase
      repeat ($urandom_range(1, 4)) run_sequence();
    end
    drain_results();
  endtask

  task automatic test_output_hold_off();
    write_reg(btcc_pkg::REG_MODE, 32'(MODE_UNDEF_HI));
    hold_go <= ~hold_go;
    burst_left = 30;
    send_item(make_item(btcc_pkg::KIND_START, 32'd0, 16'd0, 15'd0, 16'hFFFF, 10'd500));
    for (int i = 0; i < 12; i++) send_item(rand_sample());
    drain_results();
  endtask

  initial begin
    mode_r = btcc_pkg::MODE_USB;
    cutoff_r = 16'd3000;
    crit_r = 10'd100;
    run_on = 1'b0;
    run_t0 = '0;
    soc0 = '0;
    n_samples = '0;
    e_in_acc = '0;
    e_out_acc = '0;
    vphase = '0;
    dark_on = 1'b0;
    dark_t0 = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_idle_and_refusal();
    test_stop_rules();
    test_output_hold_off();
    test_random_runs();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
